// File: rtl/sliding_window_median_defines.svh
// Assertion helpers used by the checker file.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define SWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define SWM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int SIZE_W         = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Handed from a cell to the cell below it: its stored value and whether
  // that value is valid and not above the incoming sample.
  typedef struct packed {
    logic    le;
    sample_t val;
  } dn_t;

  // Handed from a cell to the cell above it: its valid bit and its entry
  // after the evicted value has been taken out of the row.
  typedef struct packed {
    logic    vld;
    logic    a_le;
    sample_t a_val;
  } up_t;

endpackage

// File: rtl/swm_cell.sv
module swm_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              upd,
  input  logic              full,
  input  swm_pkg::sample_t  s,
  input  swm_pkg::sample_t  v_old,
  input  swm_pkg::up_t      up_in,
  input  swm_pkg::dn_t      dn_in,
  output swm_pkg::up_t      up_out,
  output swm_pkg::dn_t      dn_out
);

  swm_pkg::sample_t val;
  logic             vld;
  swm_pkg::sample_t val_next;
  logic             ge;
  logic             le;
  logic             rb;

  always_comb begin
    ge = !vld || ($signed(val) >= $signed(v_old));
    le = vld && ($signed(val) <= $signed(s));
    // Everything from the first copy of the evicted value upward drops one place.
    rb = full && ge;
    up_out.vld   = vld;
    up_out.a_le  = rb ? dn_in.le  : le;
    up_out.a_val = rb ? dn_in.val : val;
    dn_out.le    = le;
    dn_out.val   = val;
    if (up_out.a_le) begin
      val_next = up_out.a_val;
    end else if (up_in.a_le) begin
      val_next = s;
    end else begin
      val_next = up_in.a_val;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
    end
    if (rst || clr) begin
      vld <= 1'b0;
    end else if (upd && !full && up_in.vld) begin
      vld <= 1'b1;
    end
  end

endmodule

// File: rtl/swm_ring.sv
module swm_ring #(
  parameter int DEPTH = swm_pkg::WINDOW_MAX_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  swm_pkg::sample_t wdata,
  input  logic [AW-1:0]    raddr,
  output swm_pkg::sample_t rdata
);

  swm_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Write-first on a collision so the oldest sample is never stale.
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sliding_window_median.sv
// Sliding-window lower-median filter. Signed 32-bit samples arrive on the
// sample channel; once window_size samples have been taken in, every further
// request yields the lower median (sorted rank (window_size-1)/2) of the last
// window_size samples. A window_size of 0 acts as 1, and one above
// WINDOW_MAX acts as WINDOW_MAX. Writing window_size restarts the sequence,
// so results resume only once the window has filled again. The filter takes
// one sample per clock for as long as the median channel keeps up: the sorted
// window lives in a row of WINDOW_MAX cells that all shift together, and the
// oldest sample is prefetched from a ring memory, read at the next pointer.
// A median passes through the emit flag and then the median register; when
// the median channel stalls, the input stalls once a finished median waits.
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         window_size_valid,
  output logic                         window_size_ready,
  input  logic [swm_pkg::SIZE_W-1:0]   window_size,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  output logic                         median_valid,
  input  logic                         median_stall,
  output logic signed [swm_pkg::SAMPLE_W-1:0] median
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam swm_pkg::dn_t DN_TOP  = '{le: 1'b0, val: '0};
  localparam swm_pkg::up_t UP_BASE = '{vld: 1'b1, a_le: 1'b1, a_val: '0};

  logic [KW-1:0]    k;
  logic [PW-1:0]    mid;
  logic [KW-1:0]    fill;
  logic [PW-1:0]    pos;
  logic             emit;
  logic [KW-1:0]    k_cfg;
  logic [PW-1:0]    mid_cfg;
  logic [PW-1:0]    pos_next;
  logic [PW-1:0]    waddr;
  logic [KW:0]      pos_inc;
  logic             cfg_wr;
  logic             acc;
  logic             full;
  logic             will_emit;
  logic             out_free;
  swm_pkg::sample_t v_old;
  swm_pkg::sample_t med_sel;
  swm_pkg::up_t     up_o [WINDOW_MAX];
  swm_pkg::dn_t     dn_o [WINDOW_MAX];

  assign window_size_ready = 1'b1;
  assign cfg_wr    = window_size_valid && window_size_ready;
  assign out_free  = !median_valid || !median_stall;
  // Hold the input while a finished median still waits for the output register.
  assign sample_stall = emit && !out_free;
  assign acc       = sample_valid && !sample_stall;
  assign full      = (fill == k);
  assign will_emit = full || ((fill + KW'(1)) == k);

  // Effective window size and median rank for a register write.
  always_comb begin
    int ws_i;
    int k_i;
    ws_i = int'(window_size);
    k_i  = (ws_i == 0) ? 1 : ws_i;
    if (k_i > WINDOW_MAX) begin
      k_i = WINDOW_MAX;
    end
    k_cfg   = KW'(k_i);
    mid_cfg = PW'((k_i - 1) >> 1);
  end

  // Advance the oldest-sample pointer only once the window is full; a window_size write resets it.
  always_comb begin
    pos_inc  = (KW + 1)'(pos) + (KW + 1)'(1);
    pos_next = pos;
    if (cfg_wr) begin
      pos_next = '0;
    end else if (acc && full) begin
      pos_next = (pos_inc >= (KW + 1)'(k)) ? '0 : pos + PW'(1);
    end
    waddr = full ? pos : fill[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= KW'(1);
      mid          <= '0;
      fill         <= '0;
      pos          <= '0;
      emit         <= 1'b0;
      median_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (cfg_wr) begin
        k    <= k_cfg;
        mid  <= mid_cfg;
        fill <= '0;
      end else if (acc && !full) begin
        fill <= fill + KW'(1);
      end
      if (acc) begin
        emit <= will_emit;
      end else if (emit && out_free) begin
        emit <= 1'b0;
      end
      if (emit && out_free) begin
        median_valid <= 1'b1;
      end else if (!median_stall) begin
        median_valid <= 1'b0;
      end
    end
    if (emit && out_free) begin
      median <= med_sel;
    end
  end

  // Arrival-order copy of the window; its read port always shows the oldest.
  swm_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (acc),
    .waddr (waddr),
    .wdata (sample),
    .raddr (pos_next),
    .rdata (v_old)
  );

  // Sorted copy: cell 0 holds the smallest value.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .clr    (cfg_wr),
      .upd    (acc),
      .full   (full),
      .s      (sample),
      .v_old  (v_old),
      .up_in  ((i == 0) ? UP_BASE : up_o[(i == 0) ? 0 : i - 1]),
      .dn_in  ((i == WINDOW_MAX - 1) ? DN_TOP : dn_o[(i == WINDOW_MAX - 1) ? i : i + 1]),
      .up_out (up_o[i]),
      .dn_out (dn_o[i])
    );
  end

  // Pick the cell at the median rank.
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (PW'(i) == mid) begin
        med_sel = med_sel | dn_o[i].val;
      end
    end
  end

endmodule

// File: rtl/swm_checker.sv
`include "sliding_window_median_defines.svh"

module swm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                window_size_valid,
  input logic                                window_size_ready,
  input logic [swm_pkg::SIZE_W-1:0]          window_size,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input logic                                median_valid,
  input logic                                median_stall,
  input logic signed [swm_pkg::SAMPLE_W-1:0] median
);

  // A stalled median must hold.
  `SWM_ASSERT(a_median_hold, median_valid && median_stall |=> median_valid && $stable(median), "median changed while stalled")
  // The input only stalls behind a stalled median.
  `SWM_ASSERT(a_stall_cause, sample_stall |-> median_valid && median_stall, "input stalled with no median waiting")
  // Drop any median on reset.
  `SWM_ASSERT_RST(a_reset_quiet, rst |=> !median_valid, "median valid straight after reset")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
